// ----- rtl/mssp_pkg.sv -----
// Shared types, constants and helpers of the multi-stepper position controller.
package mssp_pkg;

	localparam int MOTOR_COUNT_DEF = 4;

	localparam int POS_W      = 18;
	localparam int IN_POS_W   = 16;
	localparam int SPT_W      = 14;
	localparam int INTV_W     = 16;
	localparam int PIN_W      = 4;
	localparam int MODE_W     = 2;
	localparam int MOTOR_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS  = IN_POS_W;

	localparam logic [SPT_W-1:0]  SPT_RESET  = SPT_W'(4320);
	localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(300);
	localparam logic [PIN_W-1:0]  REV_RESET  = '0;

	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TARGET = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SETCUR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SPT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REV  = 2'd2;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_BWD  = 2'b11;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_TICK,
		CMD_TARGET,
		CMD_SETCUR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [MOTOR_W-1:0] motor;
		logic [POS_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [SPT_W-1:0]  steps_per_turn;
		logic [INTV_W-1:0] step_interval;
		logic [PIN_W-1:0]  reversed_mask;
	} cfg_t;

	// A turn size of zero behaves as one step per turn.
	function automatic logic [SPT_W-1:0] turn_size(input logic [SPT_W-1:0] spt);
		return (spt == '0) ? SPT_W'(1) : spt;
	endfunction

endpackage

// ----- rtl/multi_stepper_shortest_path_positioner_top.sv -----
// Top level of the multi-stepper shortest-path positioner with its configuration registers.
// Every accepted input beat yields exactly one result beat. A tick passes through the
// motor engine; when the step interval has run out and some motor still moves, the
// motors are walked once for arrival and, unless every motor has then arrived, once
// more for stepping. A set-current write goes straight to the result. A target write
// holds the front end while a one-bit-per-cycle divider wraps the position into one
// turn and while it is queued, then the engine walks the motors choosing directions.
// A two-entry command queue lets the front end take new beats while the engine works, and
// a registered result lets the engine go on while a result beat waits to be taken.
module multi_stepper_shortest_path_positioner_top import mssp_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [MODE_W-1:0]            mode,
	input  logic [MOTOR_W-1:0]           motor,
	input  logic signed [IN_POS_W-1:0]   position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [PIN_W-1:0]             step_pulses,
	output logic [PIN_W-1:0]             direction_pins,
	output logic                         moving,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	cfg_t   cfg_q;
	push_t  push;
	qstat_t qstat;
	cmd_t   head;
	logic   pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps_per_turn <= SPT_RESET;
			cfg_q.step_interval  <= INTV_RESET;
			cfg_q.reversed_mask  <= REV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPT:  cfg_q.steps_per_turn <= cfg_data[SPT_W-1:0];
				CFG_INTV: cfg_q.step_interval  <= cfg_data[INTV_W-1:0];
				CFG_REV:  cfg_q.reversed_mask  <= cfg_data[PIN_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	mssp_front #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.motor    (motor),
		.position (position),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.push     (push)
	);

	mssp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	mssp_back #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.qstat          (qstat),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.step_pulses    (step_pulses),
		.direction_pins (direction_pins),
		.moving         (moving)
	);

endmodule

// ----- rtl/mssp_front.sv -----
// Front end: accepts input beats, wraps target positions and queues commands.
module mssp_front import mssp_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [MODE_W-1:0]          mode,
	input  logic [MOTOR_W-1:0]         motor,
	input  logic signed [IN_POS_W-1:0] position,
	input  cfg_t                       cfg,
	input  qstat_t                     qstat,
	output push_t                      push
);

	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t          state_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [IN_POS_W-1:0]   dvd_q;
	logic [SPT_W-1:0]      rem_q;
	logic                  neg_q;
	logic [MOTOR_W-1:0]    motor_q;

	logic [SPT_W-1:0]  s_eff;
	logic [SPT_W:0]    rem_sh;
	logic              take;
	logic              motor_ok;
	logic [SPT_W-1:0]  wrapped;
	logic [IN_POS_W-1:0] mag;

	assign s_eff    = turn_size(cfg.steps_per_turn);
	assign rem_sh   = {rem_q, dvd_q[IN_POS_W-1]};
	assign in_ready = (state_q == F_IDLE) && !qstat.full;
	assign take     = in_valid && in_ready;
	assign motor_ok = int'(motor) < MOTOR_COUNT;
	assign mag      = position[IN_POS_W-1] ? (~position + IN_POS_W'(1)) : position;
	// A negative position with a nonzero remainder wraps up from the other side.
	assign wrapped  = (neg_q && rem_q != '0) ? (s_eff - rem_q) : rem_q;

	always_comb begin
		push = '0;
		push.cmd.motor = motor;
		push.cmd.value = {{(POS_W-IN_POS_W){position[IN_POS_W-1]}}, position};
		push.cmd.kind  = CMD_NOP;
		case (state_q)
			F_IDLE: begin
				if (take && !(mode == MODE_TARGET && motor_ok)) begin
					push.valid = 1'b1;
					if (mode == MODE_TICK) begin
						push.cmd.kind = CMD_TICK;
					end else if (mode == MODE_SETCUR && motor_ok) begin
						push.cmd.kind = CMD_SETCUR;
					end
				end
			end
			F_PUSH: begin
				push.valid     = !qstat.full;
				push.cmd.kind  = CMD_TARGET;
				push.cmd.motor = motor_q;
				push.cmd.value = POS_W'(wrapped);
			end
			default: begin
				push.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take && mode == MODE_TARGET && motor_ok) begin
						state_q <= F_DIV;
						cnt_q   <= '0;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!qstat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Restoring division of the magnitude, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && take) begin
			dvd_q   <= mag;
			rem_q   <= '0;
			neg_q   <= position[IN_POS_W-1];
			motor_q <= motor;
		end else if (state_q == F_DIV) begin
			dvd_q <= {dvd_q[IN_POS_W-2:0], 1'b0};
			if (rem_sh >= {1'b0, s_eff}) begin
				rem_q <= SPT_W'(rem_sh - {1'b0, s_eff});
			end else begin
				rem_q <= rem_sh[SPT_W-1:0];
			end
		end
	end

endmodule

// ----- rtl/mssp_queue.sv -----
// Short command queue between the front end and the motor engine.
module mssp_queue import mssp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output qstat_t qstat,
	output cmd_t   head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign qstat.full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = mem_q[rd_ptr_q];
	assign do_push     = push.valid && !qstat.full;
	assign do_pop      = pop && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule

// ----- rtl/mssp_back.sv -----
// Motor engine: walks the motors for target commands and due ticks, and registers the result beat.
module mssp_back import mssp_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  qstat_t            qstat,
	input  cmd_t              head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIN_W-1:0]  step_pulses,
	output logic [PIN_W-1:0]  direction_pins,
	output logic              moving
);

	localparam int MI_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	typedef enum logic [4:0] {
		B_IDLE   = 5'b00001,
		B_DIRS   = 5'b00010,
		B_ARRIVE = 5'b00100,
		B_MOVE   = 5'b01000,
		B_DONE   = 5'b10000
	} back_state_t;

	back_state_t        state_q;
	logic [MI_W-1:0]    idx_q;
	logic [POS_W-1:0]   cur_q [MOTOR_COUNT];
	logic [POS_W-1:0]   tgt_q [MOTOR_COUNT];
	logic [1:0]         dir_q [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] stopped_q;
	logic [INTV_W-1:0]  cnt_q;
	logic               running_q;
	logic [PIN_W-1:0]   pulses_q;
	logic               out_valid_q;
	logic [PIN_W-1:0]   step_pulses_q;
	logic [PIN_W-1:0]   direction_pins_q;
	logic               moving_q;

	logic [SPT_W-1:0]   s_eff;
	logic [POS_W-1:0]   s18;
	logic signed [POS_W:0] half19;
	logic signed [POS_W:0] diff19;
	logic [POS_W-1:0]   cur_i;
	logic [POS_W-1:0]   tgt_i;
	logic               last;
	logic [MI_W-1:0]    head_idx;
	logic [INTV_W-1:0]  cnt_next;
	logic               arrived;
	logic [POS_W-1:0]   cur_wrap;
	logic [MOTOR_COUNT-1:0] stopped_after;
	logic [PIN_W-1:0]   pins_now;
	logic               out_free;

	assign s_eff    = turn_size(cfg.steps_per_turn);
	assign s18      = POS_W'(s_eff);
	assign half19   = signed'((POS_W+1)'(s_eff >> 1));
	assign cur_i    = cur_q[idx_q];
	assign tgt_i    = tgt_q[idx_q];
	assign diff19   = signed'({tgt_i[POS_W-1], tgt_i}) - signed'({cur_i[POS_W-1], cur_i});
	assign last     = idx_q == MI_W'(MOTOR_COUNT - 1);
	assign head_idx = MI_W'(head.motor);
	assign cnt_next = (running_q && cnt_q != '1) ? cnt_q + INTV_W'(1) : cnt_q;
	assign arrived  = cur_i == tgt_i;
	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == B_IDLE) && !qstat.empty;

	always_comb begin
		if (signed'(cur_i) >= signed'(s18)) begin
			cur_wrap = cur_i - s18;
		end else if (cur_i[POS_W-1]) begin
			cur_wrap = cur_i + s18;
		end else begin
			cur_wrap = cur_i;
		end
		stopped_after = stopped_q;
		if (arrived) begin
			stopped_after[idx_q] = 1'b1;
		end
	end

	for (genvar k = 0; k < PIN_W; k++) begin : g_pins
		if (k < MOTOR_COUNT) begin : g_on
			assign pins_now[k] = (dir_q[k] == DIR_FWD) ^ cfg.reversed_mask[k];
		end else begin : g_off
			assign pins_now[k] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			stopped_q   <= '1;
			cnt_q       <= '0;
			running_q   <= 1'b0;
			pulses_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				cur_q[i] <= '0;
				tgt_q[i] <= '0;
				dir_q[i] <= DIR_NONE;
			end
		end else begin
			if (state_q == B_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						pulses_q <= '0;
						idx_q    <= '0;
						case (head.kind)
							CMD_TICK: begin
								cnt_q <= cnt_next;
								if (!(&stopped_q) && cnt_next >= cfg.step_interval) begin
									state_q <= B_ARRIVE;
								end else begin
									state_q <= B_DONE;
								end
							end
							CMD_TARGET: begin
								tgt_q[head_idx]     <= head.value;
								stopped_q[head_idx] <= 1'b0;
								if (!running_q) begin
									running_q <= 1'b1;
									cnt_q     <= '0;
								end
								state_q <= B_DIRS;
							end
							CMD_SETCUR: begin
								cur_q[head_idx]     <= head.value;
								tgt_q[head_idx]     <= head.value;
								stopped_q[head_idx] <= 1'b1;
								state_q             <= B_DONE;
							end
							default: begin
								state_q <= B_DONE;
							end
						endcase
					end
				end
				B_DIRS: begin
					// Shortest way round: move the target by one turn when it is
					// more than half a turn away.
					if (diff19 == '0) begin
						dir_q[idx_q] <= DIR_NONE;
					end else if (diff19 < -half19) begin
						tgt_q[idx_q] <= tgt_i + s18;
						dir_q[idx_q] <= DIR_FWD;
					end else if (diff19 < 0) begin
						dir_q[idx_q] <= DIR_BWD;
					end else if (diff19 <= half19) begin
						dir_q[idx_q] <= DIR_FWD;
					end else begin
						tgt_q[idx_q] <= tgt_i - s18;
						dir_q[idx_q] <= DIR_BWD;
					end
					idx_q   <= idx_q + MI_W'(1);
					state_q <= last ? B_DONE : B_DIRS;
				end
				B_ARRIVE: begin
					if (arrived) begin
						cur_q[idx_q]     <= cur_wrap;
						tgt_q[idx_q]     <= cur_wrap;
						stopped_q[idx_q] <= 1'b1;
						dir_q[idx_q]     <= DIR_NONE;
					end
					idx_q <= last ? '0 : idx_q + MI_W'(1);
					if (last) begin
						if (&stopped_after) begin
							running_q <= 1'b0;
							cnt_q     <= '0;
							state_q   <= B_DONE;
						end else begin
							state_q <= B_MOVE;
						end
					end
				end
				B_MOVE: begin
					for (int k = 0; k < PIN_W; k++) begin
						if (k < MOTOR_COUNT && idx_q == MI_W'(k)) begin
							pulses_q[k] <= !stopped_q[idx_q];
						end
					end
					case (dir_q[idx_q])
						DIR_FWD: cur_q[idx_q] <= cur_i + POS_W'(1);
						DIR_BWD: cur_q[idx_q] <= cur_i - POS_W'(1);
						default: cur_q[idx_q] <= cur_i;
					endcase
					idx_q <= idx_q + MI_W'(1);
					if (last) begin
						cnt_q   <= '0;
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_DONE && out_free) begin
			step_pulses_q    <= pulses_q;
			direction_pins_q <= pins_now;
			moving_q         <= !(&stopped_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign step_pulses    = step_pulses_q;
	assign direction_pins = direction_pins_q;
	assign moving         = moving_q;

endmodule
